>>> rtl/oled_fb_pkg.sv
// shared types, command codes and protocol constants of the oled framebuffer sequencer
package oled_fb_pkg;

    localparam logic [2:0] CMD_SET_PIXEL   = 3'd0;
    localparam logic [2:0] CMD_START_INIT  = 3'd1;
    localparam logic [2:0] CMD_START_FLUSH = 3'd2;
    localparam logic [2:0] CMD_PULL        = 3'd3;
    localparam logic [2:0] CMD_START_OFF   = 3'd4;

    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_INIT  = 2'd1,
        SEQ_FLUSH = 2'd2,
        SEQ_OFF   = 2'd3
    } seq_t;

    localparam logic [7:0] CTRL_COMMAND  = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] OP_SET_COLUMN = 8'h21;
    localparam logic [7:0] OP_SET_PAGE   = 8'h22;
    localparam logic [7:0] OP_DISPLAY_OFF = 8'hAE;
    localparam logic [7:0] OP_DISPLAY_ON  = 8'hAF;

    localparam int INIT_COUNT      = 21;
    localparam int FLUSH_CMD_COUNT = 6;

    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd60;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic take;
        logic pixel_wb;
        logic fetch_load;
    } fb_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_rmw;
        logic need_fetch;
        logic out_busy;
    } fb_stat_t;

    // setup bytes, display-on last
    function automatic logic [7:0] init_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = OP_DISPLAY_OFF;
            5'd1:    b = 8'hD5;
            5'd2:    b = 8'h80;
            5'd3:    b = 8'hA8;
            5'd4:    b = 8'h3F;
            5'd5:    b = 8'hD3;
            5'd6:    b = 8'h00;
            5'd7:    b = 8'h40;
            5'd8:    b = 8'h8D;
            5'd9:    b = 8'h14;
            5'd10:   b = 8'h20;
            5'd11:   b = 8'h00;
            5'd12:   b = 8'hA1;
            5'd13:   b = 8'hC8;
            5'd14:   b = 8'hD9;
            5'd15:   b = 8'hF1;
            5'd16:   b = 8'hDB;
            5'd17:   b = 8'h40;
            5'd18:   b = 8'hA4;
            5'd19:   b = 8'hA6;
            5'd20:   b = OP_DISPLAY_ON;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/oled_fb_ctrl.sv
// controller state machine: clearing pass, item acceptance and frame store access steps
module oled_fb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  oled_fb_pkg::fb_stat_t stat,
    output oled_fb_pkg::fb_ctl_t  ctl
);
    import oled_fb_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READY,
        ST_PIXEL,
        ST_FETCH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        ctl.clear_step = 1'b0;
        ctl.take       = 1'b0;
        ctl.pixel_wb   = 1'b0;
        ctl.fetch_load = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ctl.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_READY;
                end
            end
            ST_READY: begin
                s_tready = !stat.out_busy;
                ctl.take = s_tvalid && !stat.out_busy;
                if (ctl.take && stat.need_rmw) begin
                    state_next = ST_PIXEL;
                end else if (ctl.take && stat.need_fetch) begin
                    state_next = ST_FETCH;
                end
            end
            ST_PIXEL: begin
                ctl.pixel_wb = 1'b1;
                state_next   = ST_READY;
            end
            ST_FETCH: begin
                ctl.fetch_load = 1'b1;
                state_next     = ST_READY;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/oled_fb_datapath.sv
// datapath: frame store, sequence counters, byte formation and output register
module oled_fb_datapath #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64,
    parameter int CHUNK_BYTES  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [6:0]            cfg_wr_data,
    input  logic [39:0]           s_tdata,
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    input  oled_fb_pkg::fb_ctl_t  ctl,
    output oled_fb_pkg::fb_stat_t stat
);
    import oled_fb_pkg::*;

    localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES  = PAGE_COUNT * PANEL_WIDTH;
    localparam int FLUSH_BYTES  = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
    localparam int DATA_TRANS   = (FLUSH_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int FLUSH_TCOUNT = FLUSH_CMD_COUNT + DATA_TRANS;
    localparam int TCOUNT_MAX   = (FLUSH_TCOUNT > INIT_COUNT) ? FLUSH_TCOUNT : INIT_COUNT;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int IDX_W        = ADDR_W + 1;
    localparam int TIDX_W       = $clog2(TCOUNT_MAX);
    localparam int BIDX_W       = $clog2(CHUNK_BYTES + 1);

    // input fields
    logic [2:0] cmd;
    logic [7:0] pix_x;
    logic [6:0] pix_y;
    logic [7:0] color_or;
    assign cmd      = s_tuser;
    assign pix_x    = s_tdata[7:0];
    assign pix_y    = s_tdata[14:8];
    assign color_or = s_tdata[22:15] | s_tdata[30:23] | s_tdata[38:31];

    logic [6:0] dev_addr_reg;

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    seq_t              seq_reg, seq_next;
    logic [TIDX_W-1:0] tidx_reg, tidx_next;
    logic [BIDX_W-1:0] bidx_reg, bidx_next;
    logic [ADDR_W-1:0] data_addr_reg, data_addr_next;

    logic [ADDR_W-1:0] pix_addr_reg;
    logic [7:0]        pix_bit_reg;
    logic              pix_set_reg;

    logic [7:0] store_mem [STORE_BYTES];
    logic [7:0] mem_rdata_reg;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic [6:0] out_addr_reg;
    logic       out_start_reg;
    logic       out_end_reg;
    logic       out_seq_end_reg;

    // pixel address
    logic              in_range;
    logic [IDX_W-1:0]  idx_wide;
    logic [ADDR_W-1:0] pix_addr;
    logic [7:0]        pix_bit;

    assign in_range = ({1'b0, pix_x} < 9'(PANEL_WIDTH)) && ({1'b0, pix_y} < 8'(PANEL_HEIGHT));
    assign idx_wide = IDX_W'(pix_x) + IDX_W'(pix_y[6:3]) * IDX_W'(PANEL_WIDTH);
    assign pix_addr = idx_wide[ADDR_W-1:0];
    assign pix_bit  = 8'd1 << pix_y[2:0];

    function automatic logic [7:0] flush_byte(input logic [TIDX_W-1:0] t);
        logic [7:0] b;
        case (t)
            TIDX_W'(0): b = OP_SET_COLUMN;
            TIDX_W'(1): b = 8'h00;
            TIDX_W'(2): b = 8'(PANEL_WIDTH - 1);
            TIDX_W'(3): b = OP_SET_PAGE;
            TIDX_W'(4): b = 8'h00;
            default:    b = 8'((PANEL_HEIGHT / 8) - 1);
        endcase
        return b;
    endfunction

    // byte formation for a pull
    logic       emit;
    logic       is_data;
    logic       first;
    logic       data_last;
    logic       tr_end;
    logic       last_trans;
    logic       seq_end;
    logic [7:0] emit_byte;

    always_comb begin
        is_data   = (seq_reg == SEQ_FLUSH) && (tidx_reg >= TIDX_W'(FLUSH_CMD_COUNT));
        first     = (bidx_reg == '0);
        data_last = (bidx_reg == BIDX_W'(CHUNK_BYTES))
                 || (!first && data_addr_reg == ADDR_W'(FLUSH_BYTES - 1));
        tr_end    = is_data ? data_last : !first;
        case (seq_reg)
            SEQ_INIT:  last_trans = (tidx_reg == TIDX_W'(INIT_COUNT - 1));
            SEQ_FLUSH: last_trans = (tidx_reg == TIDX_W'(FLUSH_TCOUNT - 1));
            SEQ_OFF:   last_trans = (tidx_reg == '0);
            default:   last_trans = 1'b0;
        endcase
        seq_end = tr_end && last_trans;
        if (is_data) begin
            emit_byte = first ? CTRL_DATA : 8'h00;
        end else if (first) begin
            emit_byte = CTRL_COMMAND;
        end else begin
            case (seq_reg)
                SEQ_INIT:  emit_byte = init_byte(tidx_reg[4:0]);
                SEQ_FLUSH: emit_byte = flush_byte(tidx_reg);
                default:   emit_byte = OP_DISPLAY_OFF;
            endcase
        end
    end

    assign emit = ctl.take && (cmd == CMD_PULL) && (seq_reg != SEQ_IDLE);

    assign stat.clear_last = (clr_addr_reg == ADDR_W'(STORE_BYTES - 1));
    assign stat.need_rmw   = (cmd == CMD_SET_PIXEL) && in_range;
    assign stat.need_fetch = (cmd == CMD_PULL) && is_data && !first;
    assign stat.out_busy   = out_valid_reg && !m_tready;

    // sequence counters
    always_comb begin
        seq_next       = seq_reg;
        tidx_next      = tidx_reg;
        bidx_next      = bidx_reg;
        data_addr_next = data_addr_reg;
        if (ctl.take) begin
            case (cmd)
                CMD_START_INIT, CMD_START_FLUSH, CMD_START_OFF: begin
                    if (cmd == CMD_START_INIT) begin
                        seq_next = SEQ_INIT;
                    end else if (cmd == CMD_START_FLUSH) begin
                        seq_next = SEQ_FLUSH;
                    end else begin
                        seq_next = SEQ_OFF;
                    end
                    tidx_next      = '0;
                    bidx_next      = '0;
                    data_addr_next = '0;
                end
                CMD_PULL: begin
                    if (emit) begin
                        if (is_data && !first) begin
                            data_addr_next = data_addr_reg + ADDR_W'(1);
                        end
                        if (seq_end) begin
                            seq_next  = SEQ_IDLE;
                            tidx_next = '0;
                            bidx_next = '0;
                        end else if (tr_end) begin
                            tidx_next = tidx_reg + TIDX_W'(1);
                            bidx_next = '0;
                        end else begin
                            bidx_next = bidx_reg + BIDX_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if ((emit && !stat.need_fetch) || ctl.fetch_load) begin
            out_valid_next = 1'b1;
        end
        clr_addr_next = ctl.clear_step ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg  <= DEVICE_ADDRESS_RESET;
            clr_addr_reg  <= '0;
            seq_reg       <= SEQ_IDLE;
            tidx_reg      <= '0;
            bidx_reg      <= '0;
            data_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dev_addr_reg <= cfg_wr_data;
            end
            clr_addr_reg  <= clr_addr_next;
            seq_reg       <= seq_next;
            tidx_reg      <= tidx_next;
            bidx_reg      <= bidx_next;
            data_addr_reg <= data_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            pix_addr_reg <= pix_addr;
            pix_bit_reg  <= pix_bit;
            pix_set_reg  <= color_or[7];
        end
        if (emit) begin
            out_byte_reg    <= emit_byte;
            out_addr_reg    <= dev_addr_reg;
            out_start_reg   <= first;
            out_end_reg     <= tr_end;
            out_seq_end_reg <= seq_end;
        end else if (ctl.fetch_load) begin
            out_byte_reg <= mem_rdata_reg;
        end
    end

    // frame store: one write port, one registered read port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    assign mem_we    = ctl.clear_step || ctl.pixel_wb;
    assign mem_waddr = ctl.clear_step ? clr_addr_reg : pix_addr_reg;
    assign mem_wdata = ctl.clear_step ? 8'h00
                     : (pix_set_reg ? (mem_rdata_reg | pix_bit_reg)
                                    : (mem_rdata_reg & ~pix_bit_reg));
    assign mem_raddr = (cmd == CMD_SET_PIXEL) ? pix_addr : data_addr_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= store_mem[mem_raddr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_addr_reg, out_byte_reg};
    assign m_tuser  = {out_end_reg, out_start_reg};
    assign m_tlast  = out_seq_end_reg;

endmodule

>>> rtl/oled_framebuffer_flush_sequencer_unit.sv
// top level of the oled page framebuffer and bus byte sequencer
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser: cmd; tdata: x, y, red, green, blue
//  m_       | out       | m_tvalid/m_tready  | tdata: bus byte, address; tuser; tlast
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data: device address
//
//  start, pull and ignored commands that need no frame store read are done in ST_READY
//  a pixel write inside the panel does a store read, then a write back in ST_PIXEL
//  a pull of a data byte waits in ST_FETCH for the registered store read
//  after reset a clearing pass over all PAGE_COUNT*PANEL_WIDTH store bytes (1024 by default)
//  zeros the frame store with s_tready low; configuration writes are taken meanwhile
//  s_tready drops while a result waits in the output register and m_tready is low
module oled_framebuffer_flush_sequencer_unit #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64,
    parameter int CHUNK_BYTES  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pixel_x, pixel_y, red, green, blue, zero pad
    input  logic [2:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // bus_byte, target_address, zero pad
    output logic [1:0]  m_tuser,   // transfer_start, transfer_end
    output logic        m_tlast    // sequence_end
);
    import oled_fb_pkg::*;

    fb_ctl_t  ctl;
    fb_stat_t stat;

    oled_fb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    oled_fb_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .CHUNK_BYTES  (CHUNK_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .ctl         (ctl),
        .stat        (stat)
    );

`ifndef SYNTHESIS
    // an accepted data pull is always followed by the store byte landing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.take && stat.need_fetch) |=> ctl.fetch_load)
        else $error("data pull not followed by a store fetch");

    // an accepted in-panel pixel write is always followed by its write back
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.take && stat.need_rmw) |=> ctl.pixel_wb)
        else $error("pixel write not followed by write back");

    // the fetched byte never overwrites a result still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fetch_load |-> !m_tvalid)
        else $error("fetched byte collides with a pending transaction");
`endif

endmodule
